[rtl/prl_pkg.sv]
package prl_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_BITS   = 34;

   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int TWICE_BITS = COORD_BITS + 2;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int DOT_BITS   = PROD_BITS + 1;
   localparam int DEN_BITS   = 2 * COORD_BITS + 1;
   localparam int TERM_BITS  = TWICE_BITS + DOT_BITS;
   localparam int NUM_BITS   = TERM_BITS + 1;
   localparam int SHIFT_BITS = NUM_BITS + FRAC_BITS;
   localparam int QUO_BITS   = OUT_BITS + 1;
   localparam int MAG_BITS   = (SHIFT_BITS > QUO_BITS) ? SHIFT_BITS : QUO_BITS + 1;
   localparam int TOP_BITS   = MAG_BITS - QUO_BITS;
   localparam int CMP_BITS   = (TOP_BITS > DEN_BITS) ? TOP_BITS : DEN_BITS;

   localparam int FRONT_STAGES = 6;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_AX = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_AY = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_BX = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_BY = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
   } line_type;

   typedef struct packed {
      logic [DEN_BITS-1:0] rem;
      logic [QUO_BITS-1:0] low;
      logic [QUO_BITS-1:0] quo;
      logic                neg;
      logic                ovf;
   } lane_type;

   typedef struct packed {
      lane_type            x;
      lane_type            y;
      logic [DEN_BITS-1:0] den;
      logic                deg;
   } div_type;

   // one restoring step: brings down the next numerator bit
   function automatic lane_type div_step(lane_type a, logic [DEN_BITS-1:0] den);
      lane_type          r;
      logic [DEN_BITS:0] part;
      logic [DEN_BITS:0] diff;
      r    = a;
      part = {a.rem, a.low[QUO_BITS-1]};
      diff = part - {1'b0, den};
      r.low = {a.low[QUO_BITS-2:0], 1'b0};
      if (part >= {1'b0, den}) begin
         r.rem = diff[DEN_BITS-1:0];
         r.quo = {a.quo[QUO_BITS-2:0], 1'b1};
      end else begin
         r.rem = part[DEN_BITS-1:0];
         r.quo = {a.quo[QUO_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   // quotient too large for the cell chain when the top part already reaches den
   function automatic lane_type lane_init(logic [MAG_BITS-1:0] mag, logic neg,
                                          logic [DEN_BITS-1:0] den);
      lane_type            r;
      logic [TOP_BITS-1:0] top;
      top   = mag[MAG_BITS-1:QUO_BITS];
      r.neg = neg;
      r.ovf = CMP_BITS'(top) >= CMP_BITS'(den);
      r.rem = r.ovf ? '0 : DEN_BITS'(top);
      r.low = mag[QUO_BITS-1:0];
      r.quo = '0;
      return r;
   endfunction

endpackage

[rtl/prl_front.sv]
module prl_front (
   input  logic                clock,
   input  logic                reset,
   input  prl_pkg::line_type   line,
   input  logic                in_valid,
   output logic                in_ready,
   input  prl_pkg::coord_type  in_x,
   input  prl_pkg::coord_type  in_y,
   output logic                out_valid,
   input  logic                out_ready,
   output prl_pkg::div_type    out_data
);

   localparam int STAGES = prl_pkg::FRONT_STAGES;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] rdy;

   always_comb begin
      rdy[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign valid_in  = {valid_ff[STAGES-2:0], in_valid};
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // stage 1: differences and first products
   logic signed [prl_pkg::DIFF_BITS-1:0]  dx, dy, ux, uy;
   logic signed [prl_pkg::TWICE_BITS-1:0] s1_tx_in, s1_ty_in;
   logic signed [prl_pkg::PROD_BITS-1:0]  s1_pxd_in, s1_pyd_in, s1_sxx_in, s1_syy_in;
   logic signed [prl_pkg::PROD_BITS-1:0]  s1_pxd_ff, s1_pyd_ff, s1_sxx_ff, s1_syy_ff;
   logic signed [prl_pkg::TWICE_BITS-1:0] s1_tx_ff, s1_ty_ff;
   logic signed [prl_pkg::DIFF_BITS-1:0]  s1_dx_ff, s1_dy_ff;
   prl_pkg::coord_type                    s1_px_ff, s1_py_ff;

   always_comb begin
      dx = prl_pkg::DIFF_BITS'(line.bx) - prl_pkg::DIFF_BITS'(line.ax);
      dy = prl_pkg::DIFF_BITS'(line.by) - prl_pkg::DIFF_BITS'(line.ay);
      ux = prl_pkg::DIFF_BITS'(in_x) - prl_pkg::DIFF_BITS'(line.ax);
      uy = prl_pkg::DIFF_BITS'(in_y) - prl_pkg::DIFF_BITS'(line.ay);
      s1_tx_in = (prl_pkg::TWICE_BITS'(line.ax) <<< 1) - prl_pkg::TWICE_BITS'(in_x);
      s1_ty_in = (prl_pkg::TWICE_BITS'(line.ay) <<< 1) - prl_pkg::TWICE_BITS'(in_y);
      s1_pxd_in = prl_pkg::PROD_BITS'(ux) * prl_pkg::PROD_BITS'(dx);
      s1_pyd_in = prl_pkg::PROD_BITS'(uy) * prl_pkg::PROD_BITS'(dy);
      s1_sxx_in = prl_pkg::PROD_BITS'(dx) * prl_pkg::PROD_BITS'(dx);
      s1_syy_in = prl_pkg::PROD_BITS'(dy) * prl_pkg::PROD_BITS'(dy);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_pxd_ff <= s1_pxd_in;
         s1_pyd_ff <= s1_pyd_in;
         s1_sxx_ff <= s1_sxx_in;
         s1_syy_ff <= s1_syy_in;
         s1_tx_ff  <= s1_tx_in;
         s1_ty_ff  <= s1_ty_in;
         s1_dx_ff  <= dx;
         s1_dy_ff  <= dy;
         s1_px_ff  <= in_x;
         s1_py_ff  <= in_y;
      end
   end

   // stage 2: dot product and squared length
   logic signed [prl_pkg::DOT_BITS-1:0]   s2_dot_in, sq_sum;
   logic [prl_pkg::DEN_BITS-1:0]          s2_den_in;
   logic signed [prl_pkg::DOT_BITS-1:0]   s2_dot_ff;
   logic [prl_pkg::DEN_BITS-1:0]          s2_den_ff;
   logic                                  s2_deg_ff;
   logic signed [prl_pkg::TWICE_BITS-1:0] s2_tx_ff, s2_ty_ff;
   logic signed [prl_pkg::DIFF_BITS-1:0]  s2_dx_ff, s2_dy_ff;
   prl_pkg::coord_type                    s2_px_ff, s2_py_ff;

   always_comb begin
      s2_dot_in = prl_pkg::DOT_BITS'(s1_pxd_ff) + prl_pkg::DOT_BITS'(s1_pyd_ff);
      sq_sum    = prl_pkg::DOT_BITS'(s1_sxx_ff) + prl_pkg::DOT_BITS'(s1_syy_ff);
      s2_den_in = sq_sum[prl_pkg::DEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s2_dot_ff <= s2_dot_in;
         s2_den_ff <= s2_den_in;
         s2_deg_ff <= (s2_den_in == '0);
         s2_tx_ff  <= s1_tx_ff;
         s2_ty_ff  <= s1_ty_ff;
         s2_dx_ff  <= s1_dx_ff;
         s2_dy_ff  <= s1_dy_ff;
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
      end
   end

   // stage 3: numerator products
   logic signed [prl_pkg::DEN_BITS:0]     den_s;
   logic signed [prl_pkg::TWICE_BITS-1:0] dx2, dy2;
   logic signed [prl_pkg::TERM_BITS-1:0]  s3_m1x_in, s3_m2x_in, s3_m1y_in, s3_m2y_in;
   logic signed [prl_pkg::TERM_BITS-1:0]  s3_m1x_ff, s3_m2x_ff, s3_m1y_ff, s3_m2y_ff;
   logic [prl_pkg::DEN_BITS-1:0]          s3_den_ff;
   logic                                  s3_deg_ff;
   prl_pkg::coord_type                    s3_px_ff, s3_py_ff;

   always_comb begin
      den_s = $signed({1'b0, s2_den_ff});
      dx2   = $signed({s2_dx_ff, 1'b0});
      dy2   = $signed({s2_dy_ff, 1'b0});
      s3_m1x_in = prl_pkg::TERM_BITS'(s2_tx_ff) * prl_pkg::TERM_BITS'(den_s);
      s3_m1y_in = prl_pkg::TERM_BITS'(s2_ty_ff) * prl_pkg::TERM_BITS'(den_s);
      s3_m2x_in = prl_pkg::TERM_BITS'(dx2) * prl_pkg::TERM_BITS'(s2_dot_ff);
      s3_m2y_in = prl_pkg::TERM_BITS'(dy2) * prl_pkg::TERM_BITS'(s2_dot_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s3_m1x_ff <= s3_m1x_in;
         s3_m2x_ff <= s3_m2x_in;
         s3_m1y_ff <= s3_m1y_in;
         s3_m2y_ff <= s3_m2y_in;
         s3_den_ff <= s2_den_ff;
         s3_deg_ff <= s2_deg_ff;
         s3_px_ff  <= s2_px_ff;
         s3_py_ff  <= s2_py_ff;
      end
   end

   // stage 4: numerator sum, coinciding line points pass the point through
   logic signed [prl_pkg::NUM_BITS-1:0] s4_nx_in, s4_ny_in, s4_nx_ff, s4_ny_ff;
   logic [prl_pkg::DEN_BITS-1:0]        s4_den_in, s4_den_ff;
   logic                                s4_deg_ff;

   always_comb begin
      if (s3_deg_ff) begin
         s4_nx_in  = prl_pkg::NUM_BITS'(s3_px_ff);
         s4_ny_in  = prl_pkg::NUM_BITS'(s3_py_ff);
         s4_den_in = prl_pkg::DEN_BITS'(1);
      end else begin
         s4_nx_in  = prl_pkg::NUM_BITS'(s3_m1x_ff) + prl_pkg::NUM_BITS'(s3_m2x_ff);
         s4_ny_in  = prl_pkg::NUM_BITS'(s3_m1y_ff) + prl_pkg::NUM_BITS'(s3_m2y_ff);
         s4_den_in = s3_den_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s4_nx_ff  <= s4_nx_in;
         s4_ny_ff  <= s4_ny_in;
         s4_den_ff <= s4_den_in;
         s4_deg_ff <= s3_deg_ff;
      end
   end

   // stage 5: magnitude, scaled by the fraction bits
   logic [prl_pkg::NUM_BITS-1:0] abs_x, abs_y;
   logic [prl_pkg::MAG_BITS-1:0] s5_magx_in, s5_magy_in, s5_magx_ff, s5_magy_ff;
   logic                         s5_negx_ff, s5_negy_ff, s5_deg_ff;
   logic [prl_pkg::DEN_BITS-1:0] s5_den_ff;

   always_comb begin
      abs_x = s4_nx_ff[prl_pkg::NUM_BITS-1] ? prl_pkg::NUM_BITS'(-s4_nx_ff)
                                             : prl_pkg::NUM_BITS'(s4_nx_ff);
      abs_y = s4_ny_ff[prl_pkg::NUM_BITS-1] ? prl_pkg::NUM_BITS'(-s4_ny_ff)
                                             : prl_pkg::NUM_BITS'(s4_ny_ff);
      s5_magx_in = prl_pkg::MAG_BITS'(abs_x) << prl_pkg::FRAC_BITS;
      s5_magy_in = prl_pkg::MAG_BITS'(abs_y) << prl_pkg::FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s5_magx_ff <= s5_magx_in;
         s5_magy_ff <= s5_magy_in;
         s5_negx_ff <= s4_nx_ff[prl_pkg::NUM_BITS-1];
         s5_negy_ff <= s4_ny_ff[prl_pkg::NUM_BITS-1];
         s5_den_ff  <= s4_den_ff;
         s5_deg_ff  <= s4_deg_ff;
      end
   end

   // stage 6: overflow check and divider setup
   prl_pkg::div_type out_in, out_ff;

   always_comb begin
      out_in.x   = prl_pkg::lane_init(s5_magx_ff, s5_negx_ff, s5_den_ff);
      out_in.y   = prl_pkg::lane_init(s5_magy_ff, s5_negy_ff, s5_den_ff);
      out_in.den = s5_den_ff;
      out_in.deg = s5_deg_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         out_ff <= out_in;
      end
   end

   assign out_data = out_ff;

endmodule

[rtl/prl_div_cell.sv]
module prl_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  prl_pkg::div_type  up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output prl_pkg::div_type  dn_data
);

   logic             valid_ff;
   prl_pkg::div_type data_in, data_ff;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      data_in   = up_data;
      data_in.x = prl_pkg::div_step(up_data.x, up_data.den);
      data_in.y = prl_pkg::div_step(up_data.y, up_data.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[rtl/prl_round.sv]
module prl_round (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  prl_pkg::div_type                    up_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [prl_pkg::OUT_BITS-1:0] rsp_mirror_x,
   output logic signed [prl_pkg::OUT_BITS-1:0] rsp_mirror_y,
   output logic                                rsp_degenerate
);

   localparam int RQ_BITS = prl_pkg::QUO_BITS + 1;

   function automatic logic [RQ_BITS-1:0] round_lane(prl_pkg::lane_type a,
                                                     logic [prl_pkg::DEN_BITS-1:0] den);
      logic up;
      up = {a.rem, 1'b0} >= {1'b0, den};
      return RQ_BITS'(a.quo) + RQ_BITS'(up);
   endfunction

   function automatic logic [prl_pkg::OUT_BITS-1:0] sat_lane(logic [RQ_BITS-1:0] q,
                                                             logic neg, logic ovf);
      logic [RQ_BITS-1:0]           lim;
      logic [RQ_BITS-1:0]           mag;
      logic [prl_pkg::OUT_BITS-1:0] low;
      lim = neg ? (RQ_BITS'(1) << (prl_pkg::OUT_BITS - 1))
                : (RQ_BITS'(1) << (prl_pkg::OUT_BITS - 1)) - RQ_BITS'(1);
      mag = (ovf || q > lim) ? lim : q;
      low = mag[prl_pkg::OUT_BITS-1:0];
      return neg ? (~low + prl_pkg::OUT_BITS'(1)) : low;
   endfunction

   logic               r_valid_ff;
   logic [RQ_BITS-1:0] rqx_ff, rqy_ff;
   logic               negx_ff, negy_ff, ovfx_ff, ovfy_ff, deg_ff;
   logic               out_ready, r_ready;

   logic                                rsp_valid_ff;
   logic signed [prl_pkg::OUT_BITS-1:0] mirror_x_ff, mirror_y_ff;
   logic                                degenerate_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign r_ready   = !r_valid_ff || out_ready;
   assign up_ready  = r_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (r_ready) begin
            r_valid_ff <= up_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= r_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r_ready) begin
         rqx_ff  <= round_lane(up_data.x, up_data.den);
         rqy_ff  <= round_lane(up_data.y, up_data.den);
         negx_ff <= up_data.x.neg;
         negy_ff <= up_data.y.neg;
         ovfx_ff <= up_data.x.ovf;
         ovfy_ff <= up_data.y.ovf;
         deg_ff  <= up_data.deg;
      end
      if (out_ready) begin
         mirror_x_ff   <= sat_lane(rqx_ff, negx_ff, ovfx_ff);
         mirror_y_ff   <= sat_lane(rqy_ff, negy_ff, ovfy_ff);
         degenerate_ff <= deg_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mirror_x   = mirror_x_ff;
   assign rsp_mirror_y   = mirror_y_ff;
   assign rsp_degenerate = degenerate_ff;

endmodule

[rtl/point_reflection_across_line.sv]
// Mirrors each input point across the line through (line_ax, line_ay) and
// (line_bx, line_by); the result is signed fixed point with FRAC_BITS fraction
// bits, rounded to nearest with ties away from zero and saturated to 34 bits.
// When the two line points coincide the input point comes back unchanged with
// rsp_degenerate set. One point per cycle is accepted while req_stall is low; each point
// passes in flight through six arithmetic stages, a chain of 35 divider cells that
// each settle one quotient bit, and a rounding stage ahead of the output
// register. Line registers may only be written while no transaction is in flight.
module point_reflection_across_line (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [prl_pkg::COORD_BITS-1:0]      req_point_x,
   input  logic signed [prl_pkg::COORD_BITS-1:0]      req_point_y,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [prl_pkg::OUT_BITS-1:0]        rsp_mirror_x,
   output logic signed [prl_pkg::OUT_BITS-1:0]        rsp_mirror_y,
   output logic                                       rsp_degenerate,
   input  logic                                       csr_write_en,
   input  logic [prl_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [prl_pkg::COORD_BITS-1:0]             csr_data
);

   localparam int CELLS = prl_pkg::QUO_BITS;

   prl_pkg::line_type line_ff, line_in;

   always_comb begin
      line_in = line_ff;
      if (csr_write_en) begin
         case (csr_index)
            prl_pkg::CSR_LINE_AX: line_in.ax = $signed(csr_data);
            prl_pkg::CSR_LINE_AY: line_in.ay = $signed(csr_data);
            prl_pkg::CSR_LINE_BX: line_in.bx = $signed(csr_data);
            prl_pkg::CSR_LINE_BY: line_in.by = $signed(csr_data);
            default: line_in = line_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff.ax <= '0;
         line_ff.ay <= '0;
         line_ff.bx <= prl_pkg::COORD_BITS'(1);
         line_ff.by <= '0;
      end else begin
         line_ff <= line_in;
      end
   end

   logic             front_ready;
   logic             chain_valid [0:CELLS];
   logic             chain_ready [0:CELLS];
   prl_pkg::div_type chain_data  [0:CELLS];

   assign req_stall = !front_ready;

   prl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .line      (line_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_x      (req_point_x),
      .in_y      (req_point_y),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      prl_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   prl_round u_round (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (chain_valid[CELLS]),
      .up_ready       (chain_ready[CELLS]),
      .up_data        (chain_data[CELLS]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mirror_x   (rsp_mirror_x),
      .rsp_mirror_y   (rsp_mirror_y),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

[bench/point_reflection_across_line_checker.sv]
module point_reflection_across_line_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  prl_pkg::coord_type                  req_point_x,
   input  prl_pkg::coord_type                  req_point_y,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [prl_pkg::OUT_BITS-1:0] rsp_mirror_x,
   input  logic signed [prl_pkg::OUT_BITS-1:0] rsp_mirror_y,
   input  logic                                rsp_degenerate,
   input  logic                                csr_write_en,
   input  logic [prl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [prl_pkg::COORD_BITS-1:0]      csr_data,
   output int                                  errors,
   output int                                  pending
);

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [prl_pkg::OUT_BITS-1:0] x;
      logic signed [prl_pkg::OUT_BITS-1:0] y;
      logic                                deg;
   } mirror_type;

   prl_pkg::coord_type mirror_ax, mirror_ay, mirror_bx, mirror_by;
   mirror_type         mirror_q[$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   // scale by 2^FRAC_BITS, divide, round half away from zero, saturate
   function automatic logic signed [prl_pkg::OUT_BITS-1:0] round_scaled(wide_type num,
                                                                        logic [127:0] den);
      logic         neg;
      logic [127:0] mag, quo, rem, lim;
      neg = num < 0;
      mag = neg ? -num : num;
      mag = mag << prl_pkg::FRAC_BITS;
      quo = mag / den;
      rem = mag % den;
      if (rem >= den - rem)
         quo = quo + 1;
      lim = (128'd1 << (prl_pkg::OUT_BITS - 1)) - (neg ? 0 : 1);
      if (quo > lim)
         quo = lim;
      return neg ? -prl_pkg::OUT_BITS'(quo) : prl_pkg::OUT_BITS'(quo);
   endfunction

   function automatic mirror_type reflect_point(prl_pkg::coord_type ax_in,
                                                prl_pkg::coord_type ay_in,
                                                prl_pkg::coord_type bx_in,
                                                prl_pkg::coord_type by_in,
                                                prl_pkg::coord_type px_in,
                                                prl_pkg::coord_type py_in);
      wide_type   ax, ay, dx, dy, px, py, den, dot, nx, ny;
      mirror_type r;
      ax = ax_in;
      ay = ay_in;
      dx = bx_in;
      dy = by_in;
      px = px_in;
      py = py_in;
      dx = dx - ax;
      dy = dy - ay;
      den = dx * dx + dy * dy;
      if (den == 0) begin
         nx    = px;
         ny    = py;
         den   = 1;
         r.deg = 1'b1;
      end else begin
         dot   = (px - ax) * dx + (py - ay) * dy;
         nx    = (2 * ax - px) * den + 2 * dx * dot;
         ny    = (2 * ay - py) * den + 2 * dy * dot;
         r.deg = 1'b0;
      end
      r.x = round_scaled(nx, den);
      r.y = round_scaled(ny, den);
      return r;
   endfunction

   always @(posedge clock) begin
      mirror_type want;
      if (reset) begin
         mirror_ax = '0;
         mirror_ay = '0;
         mirror_bx = prl_pkg::coord_type'(1);
         mirror_by = '0;
         mirror_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               prl_pkg::CSR_LINE_AX: mirror_ax = csr_data;
               prl_pkg::CSR_LINE_AY: mirror_ay = csr_data;
               prl_pkg::CSR_LINE_BX: mirror_bx = csr_data;
               prl_pkg::CSR_LINE_BY: mirror_by = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (mirror_q.size() == 0) begin
               errors++;
               $display("%0t unexpected transaction: expected none, got x=%0d y=%0d deg=%0b",
                        $time, rsp_mirror_x, rsp_mirror_y, rsp_degenerate);
            end else begin
               want = mirror_q.pop_front();
               if (rsp_mirror_x !== want.x) begin
                  errors++;
                  $display("%0t mirror_x mismatch: expected %0d, got %0d",
                           $time, want.x, rsp_mirror_x);
               end
               if (rsp_mirror_y !== want.y) begin
                  errors++;
                  $display("%0t mirror_y mismatch: expected %0d, got %0d",
                           $time, want.y, rsp_mirror_y);
               end
               if (rsp_degenerate !== want.deg) begin
                  errors++;
                  $display("%0t degenerate mismatch: expected %0b, got %0b",
                           $time, want.deg, rsp_degenerate);
               end
            end
         end
         if (req_valid && !req_stall)
            mirror_q.push_back(reflect_point(mirror_ax, mirror_ay, mirror_bx, mirror_by,
                                             req_point_x, req_point_y));
      end
      pending = mirror_q.size();
   end

endmodule

[bench/point_reflection_across_line_tb.sv]
module point_reflection_across_line_tb;

   localparam int SETTLE_CYCLES  = 50;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_POINTS   = 104;
   localparam int HOLD_CYCLES    = 300;

   typedef enum int {LINE_WIDE, LINE_NARROW, LINE_POINT, LINE_CORNER} line_kind_type;

   logic                                clock;
   logic                                reset        = 1'b1;
   logic                                req_valid    = 1'b0;
   logic                                req_stall;
   prl_pkg::coord_type                  req_point_x  = '0;
   prl_pkg::coord_type                  req_point_y  = '0;
   logic                                rsp_valid;
   logic                                rsp_stall    = 1'b0;
   logic signed [prl_pkg::OUT_BITS-1:0] rsp_mirror_x;
   logic signed [prl_pkg::OUT_BITS-1:0] rsp_mirror_y;
   logic                                rsp_degenerate;
   logic                                csr_write_en = 1'b0;
   logic [prl_pkg::CSR_INDEX_BITS-1:0]  csr_index    = prl_pkg::CSR_LINE_AX;
   logic [prl_pkg::COORD_BITS-1:0]      csr_data     = '0;

   int errors;
   int pending;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   point_reflection_across_line dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mirror_x   (rsp_mirror_x),
      .rsp_mirror_y   (rsp_mirror_y),
      .rsp_degenerate (rsp_degenerate),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   point_reflection_across_line_checker mirror_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mirror_x   (rsp_mirror_x),
      .rsp_mirror_y   (rsp_mirror_y),
      .rsp_degenerate (rsp_degenerate),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .errors         (errors),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver back-pressure, with an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic prl_pkg::coord_type pick_coord();
      case ($urandom_range(5))
         0: return prl_pkg::coord_type'($urandom_range(16) - 8);
         1: return $urandom_range(1) ? prl_pkg::coord_type'(16'h7fff)
                                     : prl_pkg::coord_type'(16'h8000);
         default: return prl_pkg::coord_type'($urandom);
      endcase
   endfunction

   task automatic send_point(input prl_pkg::coord_type px, input prl_pkg::coord_type py);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [prl_pkg::CSR_INDEX_BITS-1:0] index,
                            input prl_pkg::coord_type value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_line(input prl_pkg::coord_type ax, input prl_pkg::coord_type ay,
                           input prl_pkg::coord_type bx, input prl_pkg::coord_type by);
      drain();
      write_reg(prl_pkg::CSR_LINE_AX, ax);
      write_reg(prl_pkg::CSR_LINE_AY, ay);
      write_reg(prl_pkg::CSR_LINE_BX, bx);
      write_reg(prl_pkg::CSR_LINE_BY, by);
   endtask

   task automatic random_line(input line_kind_type kind);
      prl_pkg::coord_type ax, ay, bx, by;
      ax = prl_pkg::coord_type'($urandom);
      ay = prl_pkg::coord_type'($urandom);
      bx = prl_pkg::coord_type'($urandom);
      by = prl_pkg::coord_type'($urandom);
      case (kind)
         LINE_NARROW: begin
            ax = prl_pkg::coord_type'($urandom_range(8) - 4);
            ay = prl_pkg::coord_type'($urandom_range(8) - 4);
            bx = prl_pkg::coord_type'($urandom_range(8) - 4);
            by = prl_pkg::coord_type'($urandom_range(8) - 4);
         end
         LINE_POINT: begin
            bx = ax;
            by = ay;
         end
         LINE_CORNER: begin
            ax = $urandom_range(1) ? prl_pkg::coord_type'(16'h7fff)
                                   : prl_pkg::coord_type'(16'h8000);
            ay = $urandom_range(1) ? prl_pkg::coord_type'(16'h7fff)
                                   : prl_pkg::coord_type'(16'h8000);
            bx = $urandom_range(1) ? prl_pkg::coord_type'(16'h7fff)
                                   : prl_pkg::coord_type'(16'h8000);
            by = $urandom_range(1) ? prl_pkg::coord_type'(16'h7fff)
                                   : prl_pkg::coord_type'(16'h8000);
         end
         default: ;
      endcase
      set_line(ax, ay, bx, by);
   endtask

   initial begin
      line_kind_type kind;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // line after reset runs along the x axis
      send_point(16'sd0, 16'sd0);
      send_point(16'sd32767, 16'sd32767);
      send_point(-16'sd32768, -16'sd32768);
      send_point(16'sd32767, -16'sd32768);
      send_point(-16'sd32768, 16'sd32767);
      send_point(-16'sd1, 16'sd1);

      // longest possible line, corner to corner
      set_line(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
      send_point(16'sd32767, -16'sd32768);
      send_point(-16'sd32768, 16'sd32767);
      send_point(16'sd32767, 16'sd32767);
      send_point(-16'sd32768, -16'sd32768);
      send_point(16'sd0, 16'sd0);
      send_point(16'sd12345, -16'sd54);

      set_line(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
      send_point(-16'sd32768, -16'sd32768);
      send_point(16'sd32767, 16'sd32767);
      send_point(16'sd1, 16'sd0);

      // coinciding line points
      set_line(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
      send_point(-16'sd32768, 16'sd32767);
      send_point(16'sd32767, -16'sd32768);
      send_point(16'sd0, -16'sd1);

      set_line(-16'sd3, 16'sd5, 16'sd4, -16'sd2);
      send_point(16'sd7, 16'sd7);
      send_point(-16'sd1, 16'sd2);

      for (int ph = 0; ph < 8; ph++) begin
         kind = line_kind_type'((ph + ph / 4) % 4);
         random_line(kind);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 30; stall_pct = 30; end
         endcase
         if (ph == 4)
            hold_cycles = HOLD_CYCLES;
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if ($urandom_range(3) == 0)
               send_point(pick_coord(), pick_coord());
            else
               send_point(prl_pkg::coord_type'($urandom), prl_pkg::coord_type'($urandom));
         end
      end

      drain();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
